/* hdl/ssa_pkg.sv */
// package for the slab slot allocator
// shared sizes, request and status codes and the controller-to-datapath command struct
// no dependencies
package ssa_pkg;
  localparam int MAX_SLABS      = 16;
  localparam int SLOTS_PER_SLAB = 64;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_TRIM  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFRAME = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam int RESULT_CAP = 16;

  typedef struct packed {
    logic alloc_new;     // build a slab in the lowest unused frame
    logic fill_stack;    // write one stack entry of the new slab
    logic pop_read;      // decrement count and read the stack top
    logic free_push;     // push the freed slot
    logic search_init;   // start a search: clear the first-free valid flag
    logic search_step;   // test one slab index
    logic trim_init;     // start a trim walk
    logic trim_step;     // test and maybe release one slab
  } ssa_cmd_t;

  typedef struct packed {
    logic ff_valid;
    logic full_table;
    logic no_frame;
    logic fill_done;
    logic free_bad;
    logic empty_after_pop;
    logic search_done;
    logic trim_done;
    logic trim_released;
  } ssa_stat_t;
endpackage

/* hdl/ssa_datapath.sv */
// datapath of the slab slot allocator: tables, free counts, free stack memory
// depends on ssa_pkg; driven by ssa_ctrl
module ssa_datapath
  import ssa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ssa_cmd_t   cmd,
  input  logic [3:0] frame_in,
  input  logic [5:0] slot_in,
  output ssa_stat_t  stat,
  output logic [3:0] res_frame,
  output logic [5:0] res_slot
);
  localparam int FW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int SW = (SLOTS_PER_SLAB > 1) ? $clog2(SLOTS_PER_SLAB) : 1;
  localparam int CW = $clog2(SLOTS_PER_SLAB + 1);
  localparam int NW = $clog2(MAX_SLABS + 1);

  logic [FW-1:0] frame_of_index [MAX_SLABS];
  logic [FW-1:0] index_of_frame [MAX_SLABS];
  logic [CW-1:0] slot_avail [MAX_SLABS];
  logic [SW-1:0] free_stack [MAX_SLABS*SLOTS_PER_SLAB];
  logic [MAX_SLABS-1:0] frame_used;
  logic [NW-1:0] slab_count;
  logic [FW-1:0] first_free_index;
  logic          first_free_valid;

  logic [FW-1:0] new_frame;
  logic [CW-1:0] fill_cnt;
  logic [NW:0]   walk;
  logic [SW-1:0] rd_slot;
  logic [FW-1:0] rd_frame;

  logic          lowest_found;
  logic [FW-1:0] lowest;
  always_comb begin
    lowest_found = 1'b0;
    lowest = '0;
    for (int k = MAX_SLABS - 1; k >= 0; k--) begin
      if (!frame_used[k]) begin
        lowest_found = 1'b1;
        lowest = FW'(k);
      end
    end
  end

  logic [FW-1:0] ff_frame;
  logic [CW-1:0] ff_count;
  logic [FW-1:0] in_frame;
  logic          in_frame_ok;
  logic [FW-1:0] walk_idx;
  logic [FW-1:0] walk_frame;
  logic [FW-1:0] last_frame;
  logic          walk_end;
  assign ff_frame   = frame_of_index[first_free_index];
  assign ff_count   = slot_avail[ff_frame];
  assign in_frame   = frame_in[FW-1:0];
  assign in_frame_ok = ({28'd0, frame_in} < 32'(MAX_SLABS)) && frame_used[in_frame];
  assign walk_idx   = walk[FW-1:0];
  assign walk_frame = frame_of_index[walk_idx];
  assign last_frame = frame_of_index[FW'(slab_count - NW'(1))];
  assign walk_end   = walk >= (NW+1)'(slab_count);

  assign stat.ff_valid        = first_free_valid;
  assign stat.full_table      = slab_count >= NW'(MAX_SLABS);
  assign stat.no_frame        = !lowest_found;
  assign stat.fill_done       = fill_cnt == CW'(SLOTS_PER_SLAB - 1);
  assign stat.free_bad        = !in_frame_ok
                                || slot_avail[in_frame] >= CW'(SLOTS_PER_SLAB)
                                || {26'd0, slot_in} >= 32'(SLOTS_PER_SLAB);
  assign stat.empty_after_pop = ff_count == CW'(1);
  assign stat.search_done     = walk_end || slot_avail[walk_frame] != '0;
  assign stat.trim_done       = walk_end;
  assign stat.trim_released   = !walk_end && slot_avail[walk_frame] == CW'(SLOTS_PER_SLAB);

  // one write port into the stack memory
  logic             stk_we;
  logic [FW+SW-1:0] stk_waddr;
  logic [SW-1:0]    stk_wdata;
  always_comb begin
    stk_we = cmd.fill_stack || cmd.free_push;
    if (cmd.fill_stack) begin
      stk_waddr = {new_frame, fill_cnt[SW-1:0]};
      stk_wdata = SW'(SLOTS_PER_SLAB - 1) - fill_cnt[SW-1:0];
    end else begin
      stk_waddr = {in_frame, SW'(slot_avail[in_frame])};
      stk_wdata = slot_in[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      free_stack[stk_waddr] <= stk_wdata;
    end
    if (cmd.pop_read) begin
      rd_slot <= free_stack[{ff_frame, SW'(ff_count - CW'(1))}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_used <= '0;
      slab_count <= '0;
      first_free_index <= '0;
      first_free_valid <= 1'b0;
      fill_cnt <= '0;
      walk <= '0;
    end else begin
      if (cmd.alloc_new) begin
        new_frame <= lowest;
        frame_used[lowest] <= 1'b1;
        slot_avail[lowest] <= CW'(SLOTS_PER_SLAB);
        frame_of_index[FW'(slab_count)] <= lowest;
        index_of_frame[lowest] <= FW'(slab_count);
        first_free_index <= FW'(slab_count);
        first_free_valid <= 1'b1;
        slab_count <= slab_count + NW'(1);
        fill_cnt <= '0;
      end
      if (cmd.fill_stack) begin
        fill_cnt <= fill_cnt + CW'(1);
      end
      if (cmd.pop_read) begin
        slot_avail[ff_frame] <= ff_count - CW'(1);
        rd_frame <= ff_frame;
        walk <= (NW+1)'(first_free_index) + (NW+1)'(1);
      end
      if (cmd.free_push) begin
        slot_avail[in_frame] <= slot_avail[in_frame] + CW'(1);
        if (!first_free_valid || index_of_frame[in_frame] < first_free_index) begin
          first_free_index <= index_of_frame[in_frame];
          first_free_valid <= 1'b1;
        end
      end
      if (cmd.search_init) begin
        first_free_valid <= 1'b0;
      end
      if (cmd.search_step) begin
        if (!walk_end && slot_avail[walk_frame] != '0) begin
          first_free_index <= walk_idx;
          first_free_valid <= 1'b1;
        end else begin
          walk <= walk + (NW+1)'(1);
        end
      end
      if (cmd.trim_init) begin
        walk <= '0;
      end
      if (cmd.trim_step) begin
        if (stat.trim_released) begin
          frame_used[walk_frame] <= 1'b0;
          rd_frame <= walk_frame;
          frame_of_index[walk_idx] <= last_frame;
          index_of_frame[last_frame] <= walk_idx;
          slab_count <= slab_count - NW'(1);
        end else if (!walk_end) begin
          walk <= walk + (NW+1)'(1);
        end
      end
    end
  end

  assign res_frame = 4'(rd_frame);
  assign res_slot  = 6'(rd_slot);
endmodule

/* hdl/ssa_ctrl.sv */
// controller of the slab slot allocator: request sequencing and result strobes
// depends on ssa_pkg; drives ssa_datapath
module ssa_ctrl
  import ssa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  ssa_stat_t  stat,
  input  logic [3:0] dp_frame,
  input  logic [5:0] dp_slot,
  output logic       busy,
  output ssa_cmd_t   cmd,
  output logic       done,
  output logic [1:0] status,
  output logic [3:0] frame_out,
  output logic [5:0] slot_out,
  output logic       released,
  output logic       last
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NEW   = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_ARES  = 4'd4;
  localparam logic [3:0] S_SRCH  = 4'd5;
  localparam logic [3:0] S_TRIM  = 4'd6;
  localparam logic [3:0] S_TSRCH = 4'd7;
  localparam logic [3:0] S_TRES  = 4'd8;

  logic [3:0] state, state_next;
  logic [4:0] nrel;
  logic       pend, pend_empty;
  logic [3:0] pend_frame;
  logic       accept;
  logic       res_now;
  logic [1:0] res_status;
  logic [3:0] res_frame;
  logic [5:0] res_slot;
  logic       res_released;
  logic       res_last;
  assign accept = start && !busy;
  assign busy = state != S_IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            REQ_ALLOC: begin
              if (stat.ff_valid) state_next = S_POP;
              else if (!stat.full_table && !stat.no_frame) begin
                cmd.alloc_new = 1'b1;
                state_next = S_FILL;
              end
            end
            REQ_FREE: if (!stat.free_bad) cmd.free_push = 1'b1;
            REQ_TRIM: begin
              cmd.trim_init = 1'b1;
              state_next = S_TRIM;
            end
            default: ;
          endcase
        end
      end
      S_NEW: state_next = S_FILL;
      S_FILL: begin
        cmd.fill_stack = 1'b1;
        if (stat.fill_done) state_next = S_POP;
      end
      S_POP: begin
        cmd.pop_read = 1'b1;
        state_next = S_ARES;
      end
      S_ARES: begin
        if (pend_empty) begin
          cmd.search_init = 1'b1;
          state_next = S_SRCH;
        end else state_next = S_IDLE;
      end
      S_SRCH: begin
        cmd.search_step = 1'b1;
        if (stat.search_done) state_next = S_IDLE;
      end
      S_TRIM: begin
        if (stat.trim_done || nrel == 5'(RESULT_CAP)) begin
          cmd.search_init = 1'b1;
          cmd.trim_init = 1'b1;
          state_next = S_TSRCH;
        end else begin
          cmd.trim_step = 1'b1;
          if (stat.trim_released) state_next = S_TRES;
        end
      end
      S_TRES: state_next = S_TRIM;
      S_TSRCH: begin
        cmd.search_step = 1'b1;
        if (stat.search_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a released frame is held back one slab so that the final one carries last
  always_comb begin
    res_now = 1'b0;
    res_status = ST_OK;
    res_frame = '0;
    res_slot = '0;
    res_released = 1'b0;
    res_last = 1'b1;
    if (state == S_IDLE) begin
      if (accept && req_type != REQ_TRIM
          && !(req_type == REQ_ALLOC && state_next != S_IDLE)) begin
        res_now = 1'b1;
        if (req_type == REQ_ALLOC) res_status = ST_NOFRAME;
        else if (req_type == REQ_FREE && stat.free_bad) res_status = ST_BADFREE;
      end
    end else if (state == S_ARES) begin
      res_now = 1'b1;
      res_frame = dp_frame;
      res_slot = dp_slot;
    end else if (state == S_TRES) begin
      res_now = pend;
      res_frame = pend_frame;
      res_released = 1'b1;
      res_last = 1'b0;
    end else if (state == S_TSRCH) begin
      res_now = stat.search_done;
      if (pend) begin
        res_frame = pend_frame;
        res_released = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      pend <= 1'b0;
      pend_frame <= '0;
      nrel <= '0;
      pend_empty <= 1'b0;
      status <= ST_OK;
      frame_out <= '0;
      slot_out <= '0;
      released <= 1'b0;
      last <= 1'b0;
    end else begin
      state <= state_next;
      done <= res_now;
      if (state == S_IDLE && accept) begin
        nrel <= '0;
        pend <= 1'b0;
      end else if (state == S_TRES) begin
        nrel <= nrel + 5'd1;
        pend <= 1'b1;
        pend_frame <= dp_frame;
      end
      if (state == S_POP) pend_empty <= stat.empty_after_pop;
      if (res_now) begin
        status <= res_status;
        frame_out <= res_frame;
        slot_out <= res_slot;
        released <= res_released;
        last <= res_last;
      end
    end
  end
endmodule

/* hdl/slab_slot_allocator.sv */
// slab slot allocator top level: controller and datapath
// depends on ssa_pkg, ssa_ctrl, ssa_datapath
//
// Requests are taken at a clock edge with start high and busy low; each result
// shows for one cycle with done high and the receiver cannot stall it. A free or
// an unused code leaves busy low and shows its result in the cycle after the
// request. An alloc steps through S_POP, which reads the stack top, and S_ARES,
// whose result is registered onto the outputs; a new slab first has its stack
// filled one entry a cycle in S_FILL. When the slab empties busy stays high while
// the next slab with space is searched for. A trim walks the slab table one index
// a cycle while no frame is released, each released frame also passing S_TRES,
// then searches the table again from index 0 before its final result.
module slab_slot_allocator
  import ssa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  logic [3:0] frame_in,
  input  logic [5:0] slot_in,
  output logic       busy,
  output logic       done,
  output logic [1:0] status,
  output logic [3:0] frame_out,
  output logic [5:0] slot_out,
  output logic       released,
  output logic       last
);
  ssa_cmd_t   cmd;
  ssa_stat_t  stat;
  logic [3:0] dp_frame;
  logic [5:0] dp_slot;

  ssa_ctrl u_ctrl (
    .clk, .rst, .start, .req_type, .stat, .dp_frame, .dp_slot, .busy, .cmd,
    .done, .status, .frame_out, .slot_out, .released, .last
  );

  ssa_datapath u_dp (
    .clk, .rst, .cmd, .frame_in, .slot_in, .stat,
    .res_frame(dp_frame), .res_slot(dp_slot)
  );
endmodule

/* hdl/ssa_checker.sv */
// port-level checks for the slab slot allocator
// depends on ssa_pkg; bound to slab_slot_allocator
module ssa_checker
  import ssa_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic       released,
  input logic       last
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("accept did not start work");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ST_OK || status == ST_NOFRAME || status == ST_BADFREE)
    else $error("bad status");
  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    done && released |-> status == ST_OK) else $error("release with error");
  a_last_when_idle: assert property (@(posedge clk) disable iff (rst)
    done && !busy |-> last) else $error("idle without last result");
endmodule

bind slab_slot_allocator ssa_checker u_chk (
  .clk, .rst, .start, .busy, .done, .status, .released, .last
);

/* verif/tb_slab_slot_allocator.sv */
// testbench for the slab slot allocator: directed and random alloc, free and trim requests
// predicts every result with its own model of the slab table and free stacks
// depends on ssa_pkg and slab_slot_allocator
module tb_slab_slot_allocator
  import ssa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0] req;
    logic [3:0] frame;
    logic [5:0] slot;
  } req_item_t;

  typedef struct {
    logic [1:0] status;
    logic [3:0] frame;
    logic [5:0] slot;
    logic       released;
    logic       last;
    bit         from_alloc;
  } slab_result_t;

  typedef struct {
    logic [3:0] frame;
    logic [5:0] slot;
  } slot_ref_t;

  localparam int NSLABS = 16;
  localparam int NSLOTS = 64;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] req_type = REQ_ALLOC;
  logic [3:0] frame_in = '0;
  logic [5:0] slot_in = '0;
  logic       busy, done;
  logic [1:0] status;
  logic [3:0] frame_out;
  logic [5:0] slot_out;
  logic       released, last;

  req_item_t    pending_reqs[$];
  slab_result_t expected_results[$];
  slot_ref_t    live_slots[$];

  // predictor state
  logic [3:0] frame_at[NSLABS];
  logic [3:0] index_at[NSLABS];
  int         free_cnt[NSLABS];
  logic [5:0] free_stk[NSLABS][NSLOTS];
  logic [NSLABS-1:0] frames_busy = '0;
  int         slab_total;
  int         first_free;
  bit         first_free_ok;

  int  idle_pct = 27;
  int  errors = 0;
  int  n_alloc = 0, n_free = 0, n_trim = 0, n_results = 0, n_full = 0, n_released = 0;
  longint cycles = 0;

  slab_slot_allocator i_dut (
    .clk, .rst, .start, .req_type, .frame_in, .slot_in,
    .busy, .done, .status, .frame_out, .slot_out, .released, .last
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_result(logic [1:0] st, logic [3:0] fr, logic [5:0] sl,
                                      logic rel, logic lst, bit from_alloc);
    slab_result_t r;
    r.status = st;
    r.frame = fr;
    r.slot = sl;
    r.released = rel;
    r.last = lst;
    r.from_alloc = from_alloc;
    expected_results.push_back(r);
  endfunction

  function automatic void seek_space(int from);
    first_free_ok = 0;
    for (int i = from; i < slab_total; i++) begin
      if (free_cnt[frame_at[i]] != 0) begin
        first_free = i;
        first_free_ok = 1;
        break;
      end
    end
  endfunction

  function automatic void predict_alloc();
    int f;
    f = 0;
    if (!first_free_ok) begin
      if (slab_total >= NSLABS) begin
        push_result(ST_NOFRAME, '0, '0, 1'b0, 1'b1, 1'b1);
        n_full++;
        return;
      end
      while (f < NSLABS && frames_busy[f]) f++;
      frames_busy[f] = 1'b1;
      free_cnt[f] = NSLOTS;
      for (int i = 0; i < NSLOTS; i++) free_stk[f][i] = 6'(NSLOTS - 1 - i);
      frame_at[slab_total] = 4'(f);
      index_at[f] = 4'(slab_total);
      first_free = slab_total;
      first_free_ok = 1;
      slab_total++;
    end
    f = frame_at[first_free];
    free_cnt[f]--;
    push_result(ST_OK, 4'(f), free_stk[f][free_cnt[f]], 1'b0, 1'b1, 1'b1);
    if (free_cnt[f] == 0) seek_space(first_free + 1);
  endfunction

  function automatic void predict_free(logic [3:0] f, logic [5:0] sl);
    if (!frames_busy[f] || free_cnt[f] >= NSLOTS) begin
      push_result(ST_BADFREE, '0, '0, 1'b0, 1'b1, 1'b0);
      return;
    end
    free_stk[f][free_cnt[f]] = sl;
    free_cnt[f]++;
    if (!first_free_ok || index_at[f] < first_free) begin
      first_free = index_at[f];
      first_free_ok = 1;
    end
    push_result(ST_OK, '0, '0, 1'b0, 1'b1, 1'b0);
  endfunction

  function automatic void predict_trim();
    int i, n, f, moved;
    i = 0;
    n = 0;
    while (i < slab_total && n < RESULT_CAP) begin
      f = frame_at[i];
      if (free_cnt[f] != NSLOTS) begin
        i++;
        continue;
      end
      frames_busy[f] = 1'b0;
      push_result(ST_OK, 4'(f), '0, 1'b1, 1'b0, 1'b0);
      n++;
      n_released++;
      moved = frame_at[slab_total - 1];
      frame_at[i] = 4'(moved);
      index_at[moved] = 4'(i);
      slab_total--;
    end
    seek_space(0);
    if (n == 0) push_result(ST_OK, '0, '0, 1'b0, 1'b1, 1'b0);
    else expected_results[$].last = 1'b1;
  endfunction

  function automatic void predict_request(req_item_t it);
    case (it.req)
      REQ_ALLOC: begin
        n_alloc++;
        predict_alloc();
      end
      REQ_FREE: begin
        n_free++;
        predict_free(it.frame, it.slot);
      end
      REQ_TRIM: begin
        n_trim++;
        predict_trim();
      end
      default: push_result(ST_OK, '0, '0, 1'b0, 1'b1, 1'b0);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    req_item_t it;
    bit        hold;
    hold = 0;
    if (!rst) begin
      if (start && !busy) begin
        predict_request(pending_reqs.pop_front());
      end else if (start) begin
        hold = 1;
      end
      if (!hold) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          it = pending_reqs[0];
          start <= 1'b1;
          req_type <= it.req;
          frame_in <= it.frame;
          slot_in <= it.slot;
        end else begin
          start <= 1'b0;
          req_type <= 2'($urandom);
          frame_in <= 4'($urandom);
          slot_in <= 6'($urandom);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    slab_result_t e;
    slot_ref_t    s;
    cycles++;
    if (!rst && done) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d frame=%0d slot=%0d released=%0d last=%0d",
                 $time, status, frame_out, slot_out, released, last);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.status || frame_out !== e.frame || slot_out !== e.slot ||
            released !== e.released || last !== e.last) begin
          $display("%0t: expected status=%0d frame=%0d slot=%0d released=%0d last=%0d",
                   $time, e.status, e.frame, e.slot, e.released, e.last);
          $display("%0t: actual   status=%0d frame=%0d slot=%0d released=%0d last=%0d",
                   $time, status, frame_out, slot_out, released, last);
          errors++;
        end else if (e.from_alloc && e.status == ST_OK) begin
          s.frame = frame_out;
          s.slot = slot_out;
          live_slots.push_back(s);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("slab_slot_allocator: mismatch");
      $finish;
    end
  end

  task automatic add_req(logic [1:0] rq, logic [3:0] fr, logic [5:0] sl);
    req_item_t it;
    it.req = rq;
    it.frame = fr;
    it.slot = sl;
    pending_reqs.push_back(it);
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
  endtask

  task automatic free_live();
    slot_ref_t s;
    int        k;
    wait_quiet();
    if (live_slots.size() == 0) begin
      add_req(REQ_FREE, 4'($urandom), 6'($urandom));
      return;
    end
    k = $urandom_range(live_slots.size() - 1);
    s = live_slots[k];
    live_slots.delete(k);
    add_req(REQ_FREE, s.frame, s.slot);
  endtask

  task automatic random_req();
    int p;
    p = $urandom_range(99);
    while (pending_reqs.size() > 2) @(posedge clk);
    if (p < 50) add_req(REQ_ALLOC, 4'($urandom), 6'($urandom));
    else if (p < 82) free_live();
    else if (p < 90) add_req(REQ_TRIM, 4'($urandom), 6'($urandom));
    else if (p < 97) add_req(REQ_FREE, 4'($urandom), 6'($urandom));
    else add_req(REQ_NONE, 4'($urandom), 6'($urandom));
  endtask

  initial begin
    int t0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed
    add_req(REQ_TRIM, 4'hf, 6'h3f);
    add_req(REQ_FREE, 4'h0, 6'h00);
    add_req(REQ_ALLOC, 4'hf, 6'h3f);
    add_req(REQ_ALLOC, 4'h0, 6'h00);
    add_req(REQ_FREE, 4'hf, 6'h3f);
    add_req(REQ_FREE, 4'h0, 6'h3f);
    add_req(REQ_FREE, 4'h0, 6'h00);
    add_req(REQ_FREE, 4'h0, 6'h05);
    add_req(REQ_NONE, 4'hf, 6'h3f);
    add_req(REQ_TRIM, 4'h0, 6'h00);
    add_req(REQ_TRIM, 4'h0, 6'h00);
    add_req(REQ_ALLOC, 4'h0, 6'h00);
    wait_quiet();
    live_slots.delete();

    for (int i = 0; i < 360; i++) begin
      if (i == 120) idle_pct = 67;
      if (i == 240) idle_pct = 0;
      random_req();
    end

    // drain every live slot, then trim and allocate again
    wait_quiet();
    add_req(REQ_FREE, 4'($urandom), 6'($urandom));
    while (live_slots.size() > 0) free_live();
    add_req(REQ_TRIM, 4'h0, 6'h00);
    add_req(REQ_ALLOC, 4'h0, 6'h00);

    wait_quiet();
    t0 = 0;
    while (t0 < 300 && !done) begin
      @(posedge clk);
      t0++;
    end
    repeat (5) @(posedge clk);
    $display("run covered %0d allocs (%0d out of frames), %0d frees, %0d trims",
             n_alloc, n_full, n_free, n_trim);
    $display("%0d results checked, %0d frames released", n_results, n_released);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("slab_slot_allocator: match");
    end else begin
      $display("slab_slot_allocator: mismatch");
    end
    $finish;
  end
endmodule
